>>> src/esd_pkg.sv
package esd_pkg;

   // Data capacity of the packet payload; byte positions at or past DropLimit are dropped.
   localparam int DataCapacity = 22;
   localparam logic [7:0] DropLimit = 8'(DataCapacity + 2);

   localparam logic [7:0] CharBsl   = 8'h5C;
   localparam logic [7:0] CharHexX  = 8'h78;
   localparam logic [7:0] CharDecD  = 8'h64;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharOne   = 8'h31;
   localparam logic [7:0] CharSeven = 8'h37;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowF  = 8'h66;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpF   = 8'h46;

   localparam logic ActionChar = 1'b0;
   localparam logic ActionEnd  = 1'b1;
   localparam logic KindByte   = 1'b0;
   localparam logic KindClose  = 1'b1;

   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_BSL  = 5'b00010,
      MODE_HEX  = 5'b00100,
      MODE_DEC  = 5'b01000,
      MODE_OCT  = 5'b10000
   } mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      logic [7:0] position;
      logic       dropped;
   } result_type;

   // All results caused by one input item, in delivery order.
   typedef struct packed {
      logic [1:0]             count;
      result_type [2:0]       entry;
   } group_type;

endpackage

>>> src/esd_if.sv
interface esd_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] char_in;

   modport source (output valid, output action, output char_in, input ready);
   modport sink   (input valid, input action, input char_in, output ready);
endinterface

interface esd_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_value;
   logic [7:0] position;
   logic       dropped;
   logic       last_of_run;

   modport source (output valid, output kind, output byte_value, output position,
                   output dropped, output last_of_run, input ready);
   modport sink   (input valid, input kind, input byte_value, input position,
                   input dropped, input last_of_run, output ready);
endinterface

>>> src/escape_sequence_byte_decoder_top.sv
// Backslash-escape byte decoder. Characters arrive on req_bus (action 0), and an
// end beat (action 1) closes the string. Escapes \\, \xHH, \dDDD (mod 256), \0OOO
// and \1..\7 octal runs become single bytes; a bad escape passes through as a
// backslash and the character. Each byte beat carries its packet position
// (0 command, 1 length, then data, saturating at 255) and a dropped flag for
// positions at or past data capacity plus two. The end beat flushes any pending
// escape and then yields a closing beat (kind 1) with the byte count; the state
// then returns to reset. last_of_run marks the final rsp beat of each req beat.
// Rate: one req beat per cycle when each makes at most one rsp beat and rsp is
// ready; a req beat that makes k rsp beats (k up to 3) holds req off until its
// last beat leaves the result buffer, which drains one beat per cycle while rsp
// is ready. The first rsp beat shows in the cycle after the req beat is accepted.
module escape_sequence_byte_decoder_top (
   input  logic      clock,
   input  logic      reset,
   esd_req_if.sink   req_bus,
   esd_rsp_if.source rsp_bus
);

   esd_pkg::group_type  group;
   esd_pkg::result_type head;
   logic                accept;
   logic                can_load;
   logic                rsp_valid;
   logic                last_beat;

   // ready depends only on the result buffer and rsp ready, so chars can stream back to back
   assign req_bus.ready = can_load;
   assign accept        = req_bus.valid && can_load;

   // decode state + combinational expansion of one char into up to 3 results
   esd_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .action  (req_bus.action),
      .char_in (req_bus.char_in),
      .group   (group)
   );

   // result register; shifts out one beat per cycle while rsp is ready
   esd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .group     (group),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_valid),
      .last_beat (last_beat),
      .head      (head),
      .can_load  (can_load)
   );

   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.kind        = head.kind;
   assign rsp_bus.byte_value  = head.byte_value;
   assign rsp_bus.position    = head.position;
   assign rsp_bus.dropped     = head.dropped;
   assign rsp_bus.last_of_run = last_beat;

   // an end beat always yields at least the closing beat
   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.action == esd_pkg::ActionEnd |=> rsp_bus.valid)
      else $error("no result after end beat");

   // the closing beat ends its run and carries no byte
   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind == esd_pkg::KindClose |->
         rsp_bus.last_of_run && rsp_bus.byte_value == 8'd0)
      else $error("closing beat malformed");

   // a closing beat is followed by a string restarting at position zero
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && rsp_bus.kind == esd_pkg::KindClose ##1
         rsp_bus.valid && rsp_bus.kind == esd_pkg::KindByte |-> rsp_bus.position == 8'd0)
      else $error("position not reset after end");

endmodule

>>> src/esd_decoder.sv
module esd_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  action,
   input  logic [7:0]            char_in,
   output esd_pkg::group_type    group
);

   esd_pkg::mode_type mode_ff, mode_in;
   logic [7:0] acc_ff, acc_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] idx_ff, idx_in;

   logic [2:0][7:0] vals;
   logic [1:0]      nb;
   logic            closing;
   logic [1:0]      fl_n;
   logic [7:0]      fl_v0, fl_v1;
   logic            hex_ok, dec_ok, oct_ok;
   logic [3:0]      hv;
   logic [7:0]      acc_hex, acc_dec, acc_oct;
   logic [1:0]      cnt_p1;

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [1:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {7'd0, b};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   always_comb begin
      hex_ok = 1'b1;
      hv     = 4'd0;
      if (char_in >= esd_pkg::CharZero && char_in <= esd_pkg::CharNine) begin
         hv = 4'(char_in - esd_pkg::CharZero);
      end else if (char_in >= esd_pkg::CharLowA && char_in <= esd_pkg::CharLowF) begin
         hv = 4'(char_in - esd_pkg::CharLowA + 8'd10);
      end else if (char_in >= esd_pkg::CharUpA && char_in <= esd_pkg::CharUpF) begin
         hv = 4'(char_in - esd_pkg::CharUpA + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
      dec_ok  = char_in >= esd_pkg::CharZero && char_in <= esd_pkg::CharNine;
      oct_ok  = char_in >= esd_pkg::CharZero && char_in <= esd_pkg::CharSeven;
      acc_hex = {acc_ff[3:0], 4'd0} + {4'd0, hv};
      acc_dec = {acc_ff[4:0], 3'd0} + {acc_ff[6:0], 1'b0} + (char_in - esd_pkg::CharZero);
      acc_oct = {acc_ff[4:0], 3'd0} + (char_in - esd_pkg::CharZero);
      cnt_p1  = cnt_ff + 2'd1;
   end

   // Bytes owed by a pending escape when it is cut short.
   always_comb begin
      fl_n  = 2'd0;
      fl_v0 = acc_ff;
      fl_v1 = esd_pkg::CharHexX;
      unique case (mode_ff)
         esd_pkg::MODE_BSL: begin
            fl_n  = 2'd1;
            fl_v0 = esd_pkg::CharBsl;
         end
         esd_pkg::MODE_HEX, esd_pkg::MODE_DEC: begin
            if (cnt_ff == 2'd0) begin
               fl_n  = 2'd2;
               fl_v0 = esd_pkg::CharBsl;
               fl_v1 = (mode_ff == esd_pkg::MODE_HEX) ? esd_pkg::CharHexX : esd_pkg::CharDecD;
            end else begin
               fl_n = 2'd1;
            end
         end
         esd_pkg::MODE_OCT: fl_n = 2'd1;
         default:           fl_n = 2'd0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      vals    = '0;
      nb      = 2'd0;
      closing = 1'b0;

      if (action == esd_pkg::ActionEnd) begin
         vals[0] = fl_v0;
         vals[1] = fl_v1;
         nb      = fl_n;
         closing = 1'b1;
         mode_in = esd_pkg::MODE_IDLE;
         acc_in  = 8'd0;
         cnt_in  = 2'd0;
      end else begin
         // digit runs first; a non-digit falls through to flush + fresh decode
         logic digit_ok;
         logic [7:0] acc_new;
         logic [1:0] limit;
         digit_ok = 1'b0;
         acc_new  = acc_hex;
         limit    = 2'd3;
         unique case (mode_ff)
            esd_pkg::MODE_HEX: begin
               digit_ok = hex_ok;
               acc_new  = acc_hex;
               limit    = 2'd2;
            end
            esd_pkg::MODE_DEC: begin
               digit_ok = dec_ok;
               acc_new  = acc_dec;
            end
            esd_pkg::MODE_OCT: begin
               digit_ok = oct_ok;
               acc_new  = acc_oct;
            end
            default: digit_ok = 1'b0;
         endcase

         if (mode_ff == esd_pkg::MODE_BSL) begin
            mode_in = esd_pkg::MODE_IDLE;
            acc_in  = 8'd0;
            cnt_in  = 2'd0;
            if (char_in == esd_pkg::CharHexX) begin
               mode_in = esd_pkg::MODE_HEX;
            end else if (char_in == esd_pkg::CharDecD) begin
               mode_in = esd_pkg::MODE_DEC;
            end else if (char_in == esd_pkg::CharZero) begin
               mode_in = esd_pkg::MODE_OCT;
            end else if (char_in >= esd_pkg::CharOne && char_in <= esd_pkg::CharSeven) begin
               mode_in = esd_pkg::MODE_OCT;
               acc_in  = char_in - esd_pkg::CharZero;
               cnt_in  = 2'd1;
            end else if (char_in == esd_pkg::CharBsl) begin
               vals[0] = esd_pkg::CharBsl;
               nb      = 2'd1;
            end else begin
               vals[0] = esd_pkg::CharBsl;
               vals[1] = char_in;
               nb      = 2'd2;
            end
         end else if (digit_ok) begin
            acc_in = acc_new;
            cnt_in = cnt_p1;
            if (cnt_p1 >= limit) begin
               vals[0] = acc_new;
               nb      = 2'd1;
               mode_in = esd_pkg::MODE_IDLE;
               acc_in  = 8'd0;
               cnt_in  = 2'd0;
            end
         end else begin
            vals[0] = fl_v0;
            vals[1] = fl_v1;
            acc_in  = 8'd0;
            cnt_in  = 2'd0;
            if (char_in == esd_pkg::CharBsl) begin
               mode_in = esd_pkg::MODE_BSL;
               nb      = fl_n;
            end else begin
               mode_in      = esd_pkg::MODE_IDLE;
               vals[fl_n]   = char_in;
               nb           = fl_n + 2'd1;
            end
         end
      end
   end

   always_comb begin
      logic [7:0] pos;
      group.count = nb + {1'b0, closing};
      for (int k = 0; k < 3; k++) begin
         pos = sat_add(idx_ff, 2'(k));
         if (closing && nb == 2'(k)) begin
            group.entry[k] = '{kind: esd_pkg::KindClose, byte_value: 8'd0, position: pos,
                               dropped: (pos > esd_pkg::DropLimit)};
         end else begin
            group.entry[k] = '{kind: esd_pkg::KindByte, byte_value: vals[k], position: pos,
                               dropped: (pos >= esd_pkg::DropLimit)};
         end
      end
      idx_in = closing ? 8'd0 : sat_add(idx_ff, nb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= esd_pkg::MODE_IDLE;
         acc_ff  <= 8'd0;
         cnt_ff  <= 2'd0;
         idx_ff  <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

>>> src/esd_outbuf.sv
module esd_outbuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  esd_pkg::group_type    group,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  last_beat,
   output esd_pkg::result_type   head,
   output logic                  can_load
);

   esd_pkg::result_type [2:0] entry_ff;
   logic [1:0]                rem_ff;
   logic                      fire;

   assign rsp_valid = rem_ff != 2'd0;
   assign last_beat = rem_ff == 2'd1;
   assign head      = entry_ff[0];
   assign fire      = rsp_valid && rsp_ready;
   // free once the final beat of the current group leaves
   assign can_load  = (rem_ff == 2'd0) || (last_beat && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else if (load) begin
         rem_ff <= group.count;
      end else if (fire) begin
         rem_ff <= rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= group.entry;
      end else if (fire) begin
         entry_ff[0] <= entry_ff[1];
         entry_ff[1] <= entry_ff[2];
      end
   end

endmodule

>>> verif/esd_decode_checker.sv
module esd_decode_checker
   import esd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   esd_req_if   req_mon,
   esd_rsp_if   rsp_mon,
   output int   fault_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      logic [7:0] position;
      logic       dropped;
      logic       last_of_run;
   } decode_beat_type;

   decode_beat_type expected_decodes[$];

   // decoder state as the block should hold it
   mode_type   escape_state;
   logic [7:0] digit_acc;
   logic [1:0] digits_seen;
   logic [7:0] byte_pos;

   function automatic void clear_escape();
      escape_state = MODE_IDLE;
      digit_acc    = '0;
      digits_seen  = '0;
   endfunction

   function automatic void put_byte(logic [7:0] value);
      decode_beat_type b;
      b.kind        = KindByte;
      b.byte_value  = value;
      b.position    = byte_pos;
      b.dropped     = (byte_pos >= DropLimit);
      b.last_of_run = 1'b0;
      if (byte_pos != 8'hFF) byte_pos = byte_pos + 8'd1;
      expected_decodes.push_back(b);
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
      if (c >= CharLowA && c <= CharLowF) return int'(c - CharLowA) + 10;
      if (c >= CharUpA && c <= CharUpF) return int'(c - CharUpA) + 10;
      return -1;
   endfunction

   function automatic void take_fresh(logic [7:0] c);
      if (c == CharBsl) escape_state = MODE_BSL;
      else put_byte(c);
   endfunction

   function automatic void add_digit(int base, int value, int run_len);
      digit_acc   = 8'(int'(digit_acc) * base + value);
      digits_seen = digits_seen + 2'd1;
      if (int'(digits_seen) >= run_len) begin
         put_byte(digit_acc);
         clear_escape();
      end
   endfunction

   // close whatever escape is open: lone backslash, letter with no digits, or a run
   function automatic void flush_escape();
      case (escape_state)
         MODE_BSL: put_byte(CharBsl);
         MODE_HEX, MODE_DEC: begin
            if (digits_seen == 2'd0) begin
               put_byte(CharBsl);
               put_byte(escape_state == MODE_HEX ? CharHexX : CharDecD);
            end else begin
               put_byte(digit_acc);
            end
         end
         MODE_OCT: put_byte(digit_acc);
         default: ;
      endcase
      clear_escape();
   endfunction

   function automatic void decode_beat(logic act, logic [7:0] c);
      int              first_new;
      int              hv;
      decode_beat_type tail;
      first_new = expected_decodes.size();
      if (act == ActionEnd) begin
         flush_escape();
         tail.kind        = KindClose;
         tail.byte_value  = '0;
         tail.position    = byte_pos;
         tail.dropped     = (byte_pos > DropLimit);
         tail.last_of_run = 1'b0;
         expected_decodes.push_back(tail);
         clear_escape();
         byte_pos = '0;
      end else begin
         case (escape_state)
            MODE_BSL: begin
               clear_escape();
               if (c == CharHexX) escape_state = MODE_HEX;
               else if (c == CharDecD) escape_state = MODE_DEC;
               else if (c == CharZero) escape_state = MODE_OCT;
               else if (c >= CharOne && c <= CharSeven) begin
                  escape_state = MODE_OCT;
                  digit_acc    = c - CharZero;
                  digits_seen  = 2'd1;
               end else if (c == CharBsl) begin
                  put_byte(CharBsl);
               end else begin
                  put_byte(CharBsl);
                  put_byte(c);
               end
            end
            MODE_HEX: begin
               hv = hex_digit(c);
               if (hv >= 0) add_digit(16, hv, 2);
               else begin
                  flush_escape();
                  take_fresh(c);
               end
            end
            MODE_DEC: begin
               if (c >= CharZero && c <= CharNine) add_digit(10, int'(c - CharZero), 3);
               else begin
                  flush_escape();
                  take_fresh(c);
               end
            end
            MODE_OCT: begin
               if (c >= CharZero && c <= CharSeven) add_digit(8, int'(c - CharZero), 3);
               else begin
                  flush_escape();
                  take_fresh(c);
               end
            end
            default: begin
               clear_escape();
               take_fresh(c);
            end
         endcase
      end
      if (expected_decodes.size() > first_new) begin
         tail = expected_decodes.pop_back();
         tail.last_of_run = 1'b1;
         expected_decodes.push_back(tail);
      end
   endfunction

   decode_beat_type got;
   decode_beat_type want;

   always @(posedge clock) begin
      if (reset) begin
         expected_decodes.delete();
         clear_escape();
         byte_pos    = '0;
         fault_count = 0;
      end else begin
         // results first: a beat leaving now was caused by an earlier request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.kind        = rsp_mon.kind;
            got.byte_value  = rsp_mon.byte_value;
            got.position    = rsp_mon.position;
            got.dropped     = rsp_mon.dropped;
            got.last_of_run = rsp_mon.last_of_run;
            if (expected_decodes.size() == 0) begin
               if (fault_count < 10)
                  $display("%0t: unexpected rsp beat kind %0d byte %h pos %0d drop %0d last %0d",
                           $realtime, got.kind, got.byte_value, got.position, got.dropped,
                           got.last_of_run);
               fault_count++;
            end else begin
               want = expected_decodes.pop_front();
               if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
                   got.position !== want.position || got.dropped !== want.dropped ||
                   got.last_of_run !== want.last_of_run) begin
                  if (fault_count < 10) begin
                     $write("%0t: rsp mismatch (exp/got) kind %0d/%0d byte %h/%h",
                            $realtime, want.kind, got.kind, want.byte_value,
                            got.byte_value);
                     $display(" pos %0d/%0d drop %0d/%0d last %0d/%0d",
                              want.position, got.position, want.dropped,
                              got.dropped, want.last_of_run, got.last_of_run);
                  end
                  fault_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) decode_beat(req_mon.action, req_mon.char_in);
      end
      pending_count = expected_decodes.size();
   end

endmodule

>>> verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import esd_pkg::*;

   // Run shape: ~500 req beats; one stretch with no idling on either side,
   // and one long rsp hold-off late in the run to back the decoder up.
   localparam int ItemTarget     = 500;
   localparam int CalmFrom       = 120;
   localparam int CalmTo         = 220;
   localparam int HoldOffAt      = 400;
   localparam int HoldOffCycles  = 300;
   localparam int WatchdogLimit  = 2000;
   localparam int LongStringLen  = 270;

   logic clock;
   logic reset;
   int   items_sent;
   int   fault_count;
   int   pending_count;
   logic calm;
   logic hold_armed;

   esd_req_if req_bus ();
   esd_rsp_if rsp_bus ();

   escape_sequence_byte_decoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Watches both channels, predicts every rsp beat and counts faults.
   esd_decode_checker decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   // Both sides stop idling inside the calm window.
   assign calm       = (items_sent >= CalmFrom) && (items_sent < CalmTo);
   assign hold_armed = (items_sent >= HoldOffAt);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Synchronous reset: held high from time zero, dropped at a falling edge.
   initial begin
      reset = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Sender side. Every change lands on a falling edge; a beat is taken at a
   // rising edge with valid and ready both high. Valid stays up between
   // back-to-back beats so it is assigned once per falling edge at most.
   // ---------------------------------------------------------------------------
   task automatic send_beat(input logic act, input logic [7:0] ch);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 32) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.char_in <= ch;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(ActionChar, s[i]);
   endtask

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(15);
      if (v < 10) return 8'(CharZero + v);
      // mix upper and lower case letters
      return $urandom_range(1) ? 8'(CharLowA + v - 10) : 8'(CharUpA + v - 10);
   endfunction

   // One random chunk of a command string. Mostly well-formed escapes with
   // random digit runs (including short and empty runs), plus raw bytes,
   // bad escapes and dangling backslashes as noise.
   task automatic send_token();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_beat(ActionChar, 8'($urandom_range(255)));
      end else if (pick < 40) begin
         send_text("\\\\");
      end else if (pick < 55) begin
         send_text("\\x");
         n = $urandom_range(2);
         for (int k = 0; k < n; k++) send_beat(ActionChar, hex_char());
      end else if (pick < 70) begin
         send_text("\\d");
         n = $urandom_range(3);
         for (int k = 0; k < n; k++) send_beat(ActionChar, 8'(CharZero + $urandom_range(9)));
      end else if (pick < 85) begin
         // \0 .. \7 lead digit, then a few more octal digits
         send_text("\\");
         n = $urandom_range(3);
         for (int k = 0; k <= n; k++) send_beat(ActionChar, 8'(CharZero + $urandom_range(7)));
      end else if (pick < 95) begin
         send_text("\\");
         send_beat(ActionChar, 8'($urandom_range(255)));
      end else begin
         send_text("\\");
      end
   endtask

   // ---------------------------------------------------------------------------
   // Receiver side: random ready, none in the calm window, and one long
   // hold-off so the result buffer fills and req backs up behind it.
   // ---------------------------------------------------------------------------
   initial begin : rsp_drive
      bit hold_done;
      hold_done     = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         rsp_bus.ready <= calm || ($urandom_range(99) >= 32);
      end
   end

   // Watchdog: ends the run if neither channel moves a beat for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus and verdict.
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int string_no;
      int token_total;
      items_sent      = 0;
      req_bus.valid   = 1'b0;
      req_bus.action  = ActionChar;
      req_bus.char_in = '0;
      @(negedge clock iff !reset);

      // Directed: raw extremes, zero byte, every escape form but a \1..\7 octal run,
      // a bad escape, a letter with no digits, a run cut short by a new escape, and an
      // end beat landing while an escape letter is still open.
      send_text("A");
      send_beat(ActionChar, 8'h00);
      send_beat(ActionChar, 8'hFF);
      send_text("\\\\");
      send_text("\\xFf");
      send_text("\\d999");   // wraps modulo 256
      send_text("\\q");
      send_text("\\xg");
      send_text("\\07\\d");
      send_beat(ActionEnd, 8'h00);

      // Random strings. The fourth one is long raw data so the position runs
      // past the drop limit and saturates; the rest are short, some empty.
      string_no = 0;
      while (items_sent < ItemTarget) begin
         if (string_no == 3) begin
            for (int k = 0; k < LongStringLen; k++)
               send_beat(ActionChar, 8'($urandom_range(255)));
         end else begin
            token_total = $urandom_range(30);
            for (int k = 0; k < token_total; k++) send_token();
         end
         // char_in is don't-care on the end beat; keep it random
         send_beat(ActionEnd, 8'($urandom_range(255)));
         string_no++;
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // Drain: wait for every predicted beat, then keep watching to catch strays.
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fault_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
